// ----- src/pbts_pkg.sv -----
// Package for the priority bitmap task scheduler.
// Holds field widths, default sizes, the operation codes and the sequencer states.
// No dependencies.
package pbts_pkg;

    // Fixed field widths of the transfer payloads
    localparam int OP_W      = 3;
    localparam int TASK_ID_W = 4;
    localparam int PRIO_IN_W = 5;
    localparam int LOCK_W    = 8;

    // Default sizes of the task table and the priority table
    localparam int NUM_PRIORITIES_DEF = 32;
    localparam int NUM_TASKS_DEF      = 16;

    // Saturation point of the lock counter
    localparam logic [LOCK_W-1:0] LOCK_MAX = 8'd255;

    // Operation codes (codes 6 and 7 only report status)
    typedef enum logic [OP_W-1:0] {
        OP_MAKE_READY = 3'd0,
        OP_UNREADY    = 3'd1,
        OP_REMOVE     = 3'd2,
        OP_LOCK       = 3'd3,
        OP_UNLOCK     = 3'd4,
        OP_SCHEDULE   = 3'd5
    } op_t;

    // Sequencer states, one-hot
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_READ1 = 6'b000010,
        ST_READ2 = 6'b000100,
        ST_WRITE = 6'b001000,
        ST_FIND  = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

endpackage

// ----- src/pbts_req_if.sv -----
// Request channel of the scheduler: valid/ready plus one operation item.
// Depends on pbts_pkg for the field widths.
interface pbts_req_if;

    logic                                valid;
    logic                                ready;
    logic [pbts_pkg::OP_W-1:0]           operation;
    logic [pbts_pkg::TASK_ID_W-1:0]      task_id;
    logic [pbts_pkg::PRIO_IN_W-1:0]      prio;

    modport source (output valid, output operation, output task_id, output prio,
                    input ready);
    modport sink   (input valid, input operation, input task_id, input prio,
                    output ready);

endinterface

// ----- src/pbts_rsp_if.sv -----
// Response channel of the scheduler: valid/ready plus one status item.
// Depends on pbts_pkg for the field widths.
interface pbts_rsp_if;

    logic                                valid;
    logic                                ready;
    logic                                switch_now;
    logic [pbts_pkg::TASK_ID_W-1:0]      next_task;
    logic                                none_ready;
    logic [pbts_pkg::PRIO_IN_W-1:0]      top_prio;
    logic [pbts_pkg::LOCK_W-1:0]         lock_level;

    modport source (output valid, output switch_now, output next_task,
                    output none_ready, output top_prio, output lock_level,
                    input ready);
    modport sink   (input valid, input switch_now, input next_task,
                    input none_ready, input top_prio, input lock_level,
                    output ready);

endinterface

// ----- src/pbts_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pbts_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write on enable, read every cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- src/priority_bitmap_task_scheduler_unit.sv -----
// Priority bitmap ready-queue scheduler, top level.
// Depends on pbts_pkg, pbts_req_if, pbts_rsp_if and pbts_ram.
//
// Usage:
//   req carries one operation per transfer: make ready, unready, remove, lock,
//   unlock or schedule, with the task id and priority it concerns. rsp returns
//   exactly one status item per request: switch request, next task, empty
//   flag, top priority and the lock count after the operation.
// Sequencing:
//   One small sequencer walks each request through the linked-list tables,
//   which sit in registered-read RAMs.
//   Lock, unlock, schedule and unused codes pass through FIND and DONE;
//   unready, remove and make ready that leave the lists alone add READ1;
//   make ready with an append adds READ1 and READ2; unlinking a task adds
//   READ1, READ2 and WRITE. req.ready is high only while the sequencer is
//   idle, so a new request waits until the sequencer has finished the last
//   one; the list unlink with its dependent reads and writes takes longest.
//   The result sits in an output register; a new request is taken while it
//   waits, and a finished request holds in its last step until rsp drains.
// Reset:
//   rst_n clears the bitmap, the ready and queued flags, the lock count and
//   the running task. The list RAMs need no clearing: an entry is only read
//   once the bitmap or a queued flag shows it was written.
module priority_bitmap_task_scheduler_unit #(
    parameter int NUM_PRIORITIES = pbts_pkg::NUM_PRIORITIES_DEF,
    parameter int NUM_TASKS      = pbts_pkg::NUM_TASKS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    pbts_req_if.sink      req,
    pbts_rsp_if.source    rsp
);

    localparam int TASK_W = $clog2(NUM_TASKS);
    localparam int PRIO_W = $clog2(NUM_PRIORITIES);
    localparam int LOCK_W = pbts_pkg::LOCK_W;

    // Sequencer and control state
    pbts_pkg::state_t            state_reg, state_next;
    logic [NUM_PRIORITIES-1:0]   bitmap_reg, bitmap_next;
    logic [NUM_TASKS-1:0]        ready_flag_reg, ready_flag_next;
    logic [NUM_TASKS-1:0]        queued_flag_reg, queued_flag_next;
    logic [LOCK_W-1:0]           lock_reg, lock_next;
    logic [TASK_W-1:0]           run_task_reg, run_task_next;
    logic                        run_valid_reg, run_valid_next;
    logic                        do_append_reg, do_append_next;
    logic                        out_valid_reg, out_valid_next;

    // Request and working payload
    pbts_pkg::op_t               op_reg;
    logic [pbts_pkg::TASK_ID_W-1:0] tid_reg;
    logic [pbts_pkg::PRIO_IN_W-1:0] prio_in_reg;
    logic [PRIO_W-1:0]           qp_reg, qp_next;
    logic [PRIO_W-1:0]           top_reg, top_next;
    logic                        any_reg, any_next;

    // Result payload
    logic                        sw_reg, sw_next;
    logic [pbts_pkg::TASK_ID_W-1:0] next_task_reg, next_task_next;
    logic                        none_reg, none_next;
    logic [pbts_pkg::PRIO_IN_W-1:0] top_prio_reg, top_prio_next;
    logic [LOCK_W-1:0]           lock_out_reg, lock_out_next;

    // Index decode
    logic [8:0]                  t_ext;
    logic [6:0]                  p_ext;
    logic [TASK_W-1:0]           t_idx;
    logic [PRIO_W-1:0]           p_idx;
    logic                        task_ok;
    logic                        prio_ok;

    // Lowest set priority
    logic [NUM_PRIORITIES-1:0]   low_bit;
    logic [PRIO_W-1:0]           enc;

    // Table ports
    logic                        head_we, tail_we, next_we, prev_we, qprio_we;
    logic [PRIO_W-1:0]           head_wr_addr, tail_wr_addr;
    logic [TASK_W-1:0]           head_wr_data, tail_wr_data;
    logic [TASK_W-1:0]           next_wr_addr, next_wr_data;
    logic [TASK_W-1:0]           prev_wr_addr, prev_wr_data;
    logic [PRIO_W-1:0]           head_rd_addr, tail_rd_addr;
    logic [TASK_W-1:0]           head_rdata, tail_rdata, next_rdata, prev_rdata;
    logic [PRIO_W-1:0]           qprio_rdata;

    // Scheduling decision
    logic                        sched_req;
    logic                        accept;
    logic [8:0]                  head_ext;
    logic [6:0]                  top_ext;

    assign accept = req.valid && req.ready;

    assign t_ext   = {5'd0, tid_reg};
    assign p_ext   = {2'd0, prio_in_reg};
    assign t_idx   = t_ext[TASK_W-1:0];
    assign p_idx   = p_ext[PRIO_W-1:0];
    assign task_ok = t_ext < 9'(NUM_TASKS);
    assign prio_ok = p_ext < 7'(NUM_PRIORITIES);

    // Isolate the lowest set bit with one add, then encode it
    assign low_bit = bitmap_reg & (~bitmap_reg + NUM_PRIORITIES'(1));

    always_comb
    begin
        enc = '0;
        for (int i = 0; i < NUM_PRIORITIES; i++)
        begin
            if (low_bit[i])
            begin
                enc = enc | PRIO_W'(i);
            end
        end
    end

    // Read addresses follow the sequencer step; keep the top head while the result waits
    assign head_rd_addr = (state_reg == pbts_pkg::ST_FIND ||
                           state_reg == pbts_pkg::ST_DONE) ? enc : qprio_rdata;
    assign tail_rd_addr = (state_reg == pbts_pkg::ST_READ1) ? p_idx : qprio_rdata;

    assign head_ext = {{(9 - TASK_W){1'b0}}, head_rdata};
    assign top_ext  = {{(7 - PRIO_W){1'b0}}, top_reg};

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        bitmap_next      = bitmap_reg;
        ready_flag_next  = ready_flag_reg;
        queued_flag_next = queued_flag_reg;
        lock_next        = lock_reg;
        run_task_next    = run_task_reg;
        run_valid_next   = run_valid_reg;
        do_append_next   = do_append_reg;
        out_valid_next   = out_valid_reg;
        qp_next          = qp_reg;
        top_next         = top_reg;
        any_next         = any_reg;
        sw_next          = sw_reg;
        next_task_next   = next_task_reg;
        none_next        = none_reg;
        top_prio_next    = top_prio_reg;
        lock_out_next    = lock_out_reg;
        sched_req        = 1'b0;

        head_we      = 1'b0;
        tail_we      = 1'b0;
        next_we      = 1'b0;
        prev_we      = 1'b0;
        qprio_we     = 1'b0;
        head_wr_addr = p_idx;
        head_wr_data = t_idx;
        tail_wr_addr = p_idx;
        tail_wr_data = t_idx;
        next_wr_addr = tail_rdata;
        next_wr_data = t_idx;
        prev_wr_addr = t_idx;
        prev_wr_data = tail_rdata;

        // Drain the output register
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            pbts_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.operation == pbts_pkg::OP_MAKE_READY ||
                        req.operation == pbts_pkg::OP_UNREADY ||
                        req.operation == pbts_pkg::OP_REMOVE)
                    begin
                        state_next = pbts_pkg::ST_READ1;
                    end
                    else
                    begin
                        state_next = pbts_pkg::ST_FIND;
                    end
                end
            end

            // Update the flags; tail and queued priority reads are in flight
            pbts_pkg::ST_READ1:
            begin
                do_append_next = 1'b0;
                state_next     = pbts_pkg::ST_FIND;
                unique case (op_reg)
                    pbts_pkg::OP_MAKE_READY:
                    begin
                        if (task_ok && prio_ok)
                        begin
                            ready_flag_next[t_idx] = 1'b1;
                            if (!queued_flag_reg[t_idx])
                            begin
                                queued_flag_next[t_idx] = 1'b1;
                                do_append_next          = 1'b1;
                                state_next              = pbts_pkg::ST_READ2;
                            end
                        end
                    end
                    pbts_pkg::OP_UNREADY:
                    begin
                        if (task_ok && ready_flag_reg[t_idx])
                        begin
                            ready_flag_next[t_idx] = 1'b0;
                            if (queued_flag_reg[t_idx])
                            begin
                                queued_flag_next[t_idx] = 1'b0;
                                state_next              = pbts_pkg::ST_READ2;
                            end
                        end
                    end
                    pbts_pkg::OP_REMOVE:
                    begin
                        if (task_ok && queued_flag_reg[t_idx])
                        begin
                            queued_flag_next[t_idx] = 1'b0;
                            state_next              = pbts_pkg::ST_READ2;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            // Append at the tail, or start the unlink reads
            pbts_pkg::ST_READ2:
            begin
                if (do_append_reg)
                begin
                    if (!bitmap_reg[p_idx])
                    begin
                        head_we = 1'b1;
                    end
                    else
                    begin
                        next_we = 1'b1;
                        prev_we = 1'b1;
                    end
                    tail_we              = 1'b1;
                    qprio_we             = 1'b1;
                    bitmap_next[p_idx]   = 1'b1;
                    state_next           = pbts_pkg::ST_FIND;
                end
                else
                begin
                    qp_next    = qprio_rdata;
                    state_next = pbts_pkg::ST_WRITE;
                end
            end

            // Relink the neighbors, or empty the priority
            pbts_pkg::ST_WRITE:
            begin
                head_wr_addr = qp_reg;
                head_wr_data = next_rdata;
                tail_wr_addr = qp_reg;
                tail_wr_data = prev_rdata;
                next_wr_addr = prev_rdata;
                next_wr_data = next_rdata;
                prev_wr_addr = next_rdata;
                prev_wr_data = prev_rdata;
                if (head_rdata != tail_rdata)
                begin
                    if (head_rdata == t_idx)
                    begin
                        head_we = 1'b1;
                    end
                    else
                    begin
                        next_we = 1'b1;
                    end
                    if (tail_rdata == t_idx)
                    begin
                        tail_we = 1'b1;
                    end
                    else
                    begin
                        prev_we = 1'b1;
                    end
                end
                else
                begin
                    bitmap_next[qp_reg] = 1'b0;
                end
                state_next = pbts_pkg::ST_FIND;
            end

            // Capture the top priority; its head read is in flight
            pbts_pkg::ST_FIND:
            begin
                any_next   = |bitmap_reg;
                top_next   = enc;
                state_next = pbts_pkg::ST_DONE;
            end

            // Lock update, scheduling decision, load the result
            pbts_pkg::ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    unique case (op_reg)
                        pbts_pkg::OP_LOCK:
                        begin
                            if (lock_reg != pbts_pkg::LOCK_MAX)
                            begin
                                lock_next = lock_reg + LOCK_W'(1);
                            end
                        end
                        pbts_pkg::OP_UNLOCK:
                        begin
                            if (lock_reg != '0)
                            begin
                                lock_next = lock_reg - LOCK_W'(1);
                                sched_req = (lock_reg == LOCK_W'(1));
                            end
                        end
                        pbts_pkg::OP_SCHEDULE:
                        begin
                            sched_req = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase

                    sw_next = sched_req && (lock_next == '0) && any_reg &&
                              !(run_valid_reg && head_rdata == run_task_reg);
                    if (sw_next)
                    begin
                        run_task_next  = head_rdata;
                        run_valid_next = 1'b1;
                    end

                    next_task_next = any_reg ? head_ext[pbts_pkg::TASK_ID_W-1:0] : '0;
                    none_next      = !any_reg;
                    top_prio_next  = top_ext[pbts_pkg::PRIO_IN_W-1:0];
                    lock_out_next  = lock_next;
                    out_valid_next = 1'b1;
                    state_next     = pbts_pkg::ST_IDLE;
                end
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= pbts_pkg::ST_IDLE;
            bitmap_reg      <= '0;
            ready_flag_reg  <= '0;
            queued_flag_reg <= '0;
            lock_reg        <= '0;
            run_task_reg    <= '0;
            run_valid_reg   <= 1'b0;
            do_append_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            bitmap_reg      <= bitmap_next;
            ready_flag_reg  <= ready_flag_next;
            queued_flag_reg <= queued_flag_next;
            lock_reg        <= lock_next;
            run_task_reg    <= run_task_next;
            run_valid_reg   <= run_valid_next;
            do_append_reg   <= do_append_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= pbts_pkg::op_t'(req.operation);
            tid_reg     <= req.task_id;
            prio_in_reg <= req.prio;
        end
        qp_reg        <= qp_next;
        top_reg       <= top_next;
        any_reg       <= any_next;
        sw_reg        <= sw_next;
        next_task_reg <= next_task_next;
        none_reg      <= none_next;
        top_prio_reg  <= top_prio_next;
        lock_out_reg  <= lock_out_next;
    end

    // Per-priority heads and tails
    pbts_ram #(.WIDTH(TASK_W), .DEPTH(NUM_PRIORITIES)) u_head_ram (
        .clk     (clk),
        .we      (head_we),
        .wr_addr (head_wr_addr),
        .wr_data (head_wr_data),
        .rd_addr (head_rd_addr),
        .rd_data (head_rdata)
    );

    pbts_ram #(.WIDTH(TASK_W), .DEPTH(NUM_PRIORITIES)) u_tail_ram (
        .clk     (clk),
        .we      (tail_we),
        .wr_addr (tail_wr_addr),
        .wr_data (tail_wr_data),
        .rd_addr (tail_rd_addr),
        .rd_data (tail_rdata)
    );

    // Per-task links and the priority each queued task sits in
    pbts_ram #(.WIDTH(TASK_W), .DEPTH(NUM_TASKS)) u_next_ram (
        .clk     (clk),
        .we      (next_we),
        .wr_addr (next_wr_addr),
        .wr_data (next_wr_data),
        .rd_addr (t_idx),
        .rd_data (next_rdata)
    );

    pbts_ram #(.WIDTH(TASK_W), .DEPTH(NUM_TASKS)) u_prev_ram (
        .clk     (clk),
        .we      (prev_we),
        .wr_addr (prev_wr_addr),
        .wr_data (prev_wr_data),
        .rd_addr (t_idx),
        .rd_data (prev_rdata)
    );

    pbts_ram #(.WIDTH(PRIO_W), .DEPTH(NUM_TASKS)) u_qprio_ram (
        .clk     (clk),
        .we      (qprio_we),
        .wr_addr (t_idx),
        .wr_data (p_idx),
        .rd_addr (t_idx),
        .rd_data (qprio_rdata)
    );

    // Channel handshakes and result
    assign req.ready      = (state_reg == pbts_pkg::ST_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.switch_now = sw_reg;
    assign rsp.next_task  = next_task_reg;
    assign rsp.none_ready = none_reg;
    assign rsp.top_prio   = top_prio_reg;
    assign rsp.lock_level = lock_out_reg;

endmodule

// ----- src/pbts_checker.sv -----
// Port-level checker for the scheduler, bound to the top level.
// Depends on pbts_pkg for the field widths.
module pbts_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic                                switch_now,
    input logic [pbts_pkg::TASK_ID_W-1:0]      next_task,
    input logic                                none_ready,
    input logic [pbts_pkg::PRIO_IN_W-1:0]      top_prio,
    input logic [pbts_pkg::LOCK_W-1:0]         lock_level
);

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(switch_now) && $stable(next_task) &&
             $stable(none_ready) && $stable(top_prio) && $stable(lock_level)))
        else $error("result changed while stalled");

    // An empty bitmap reports task and priority zero
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && none_ready) |-> (next_task == '0 && top_prio == '0))
        else $error("empty status with nonzero task or priority");

    // A switch needs a ready task and an unlocked scheduler
    a_switch_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && switch_now) |-> (!none_ready && lock_level == '0))
        else $error("switch requested while empty or locked");

    // The sequencer is busy right after taking a request
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request taken while busy");

endmodule

bind priority_bitmap_task_scheduler_unit pbts_checker u_pbts_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (req.valid),
    .in_ready   (req.ready),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .switch_now (rsp.switch_now),
    .next_task  (rsp.next_task),
    .none_ready (rsp.none_ready),
    .top_prio   (rsp.top_prio),
    .lock_level (rsp.lock_level)
);

// ----- bench/tb.sv -----
// Self-checking bench for priority_bitmap_task_scheduler_unit: directed and random
// operations, each result compared with a predicted status item.
// Depends on pbts_pkg, pbts_req_if, pbts_rsp_if and the scheduler RTL.
`timescale 1ns / 100ps

module tb;

    localparam int NP          = pbts_pkg::NUM_PRIORITIES_DEF;
    localparam int NT          = pbts_pkg::NUM_TASKS_DEF;
    localparam int OPW         = pbts_pkg::OP_W;
    localparam int TW          = pbts_pkg::TASK_ID_W;
    localparam int PW          = pbts_pkg::PRIO_IN_W;
    localparam int LW          = pbts_pkg::LOCK_W;
    localparam int LOCK_TOP    = int'(pbts_pkg::LOCK_MAX);
    localparam int LIMIT       = 400000;
    localparam int RANDOM_OPS  = 220;
    localparam int DRAIN_WAIT  = 20;

    // Codes the block accepts but does not act on
    localparam int OP_SPARE_6 = 6;
    localparam int OP_SPARE_7 = 7;

    typedef struct packed {
        logic          switch_now;
        logic [TW-1:0] next_task;
        logic          none_ready;
        logic [PW-1:0] top_prio;
        logic [LW-1:0] lock_level;
    } status_t;

    // Shadow of the ready queues and the status items they lead to
    class sched_scoreboard;
        logic [NP-1:0]        bitmap;
        int                   fill_cnt  [NP];
        int                   q_head    [NP];
        int                   q_tail    [NP];
        int                   link_fwd  [NT];
        int                   link_back [NT];
        bit                   is_ready  [NT];
        bit                   is_queued [NT];
        int                   home_prio [NT];
        int                   lock_cnt;
        int                   cur_task;
        bit                   cur_valid;
        status_t              want_q[$];
        int                   errors;
        int                   checked;
        int                   switches;
        int                   empties;
        int                   sat_hits;

        function new();
            bitmap    = '0;
            lock_cnt  = 0;
            cur_task  = 0;
            cur_valid = 0;
            for (int i = 0; i < NP; i++)
            begin
                fill_cnt[i] = 0;
                q_head[i]   = 0;
                q_tail[i]   = 0;
            end
            for (int i = 0; i < NT; i++)
            begin
                link_fwd[i]  = 0;
                link_back[i] = 0;
                is_ready[i]  = 0;
                is_queued[i] = 0;
                home_prio[i] = 0;
            end
            errors   = 0;
            checked  = 0;
            switches = 0;
            empties  = 0;
            sat_hits = 0;
        endfunction

        // Append a task at the tail of its priority
        function void enqueue(int t, int p);
            if (fill_cnt[p] == 0)
                q_head[p] = t;
            else
            begin
                link_fwd[q_tail[p]] = t;
                link_back[t]        = q_tail[p];
            end
            q_tail[p]    = t;
            fill_cnt[p]  = fill_cnt[p] + 1;
            bitmap[p]    = 1'b1;
            is_queued[t] = 1;
            home_prio[t] = p;
        endfunction

        // Unlink a task from the priority it sits in
        function void detach(int t);
            int p;
            p = home_prio[t];
            if (fill_cnt[p] > 1)
            begin
                if (q_head[p] == t)
                    q_head[p] = link_fwd[t];
                else
                    link_fwd[link_back[t]] = link_fwd[t];
                if (q_tail[p] == t)
                    q_tail[p] = link_back[t];
                else
                    link_back[link_fwd[t]] = link_back[t];
            end
            if (fill_cnt[p] > 0)
                fill_cnt[p] = fill_cnt[p] - 1;
            if (fill_cnt[p] == 0)
                bitmap[p] = 1'b0;
            is_queued[t] = 0;
        endfunction

        function bit find_top(output int top);
            for (int p = 0; p < NP; p++)
            begin
                if (bitmap[p])
                begin
                    top = p;
                    return 1;
                end
            end
            top = 0;
            return 0;
        endfunction

        // Pick the best head; request a switch when it is new and unlocked
        function bit dispatch();
            int top;
            int pick;
            if (lock_cnt != 0)
                return 0;
            if (!find_top(top))
                return 0;
            pick = q_head[top];
            if (cur_valid && pick == cur_task)
                return 0;
            cur_task  = pick;
            cur_valid = 1;
            return 1;
        endfunction

        // Apply one accepted request and queue the status it must produce
        function void note_request(logic [OPW-1:0] op, logic [TW-1:0] t,
                                   logic [PW-1:0] p);
            int      ti;
            int      pi;
            int      top;
            bit      sw;
            bit      any;
            status_t s;
            ti = int'(t);
            pi = int'(p);
            sw = 0;
            case (op)
                pbts_pkg::OP_MAKE_READY:
                    if (ti < NT && pi < NP)
                    begin
                        if (!is_queued[ti])
                            enqueue(ti, pi);
                        is_ready[ti] = 1;
                    end
                pbts_pkg::OP_UNREADY:
                    if (ti < NT && is_ready[ti])
                    begin
                        if (is_queued[ti])
                            detach(ti);
                        is_ready[ti] = 0;
                    end
                pbts_pkg::OP_REMOVE:
                    if (ti < NT && is_queued[ti])
                        detach(ti);
                pbts_pkg::OP_LOCK:
                    if (lock_cnt < LOCK_TOP)
                        lock_cnt = lock_cnt + 1;
                    else
                        sat_hits++;
                pbts_pkg::OP_UNLOCK:
                    if (lock_cnt != 0)
                    begin
                        lock_cnt = lock_cnt - 1;
                        if (lock_cnt == 0)
                            sw = dispatch();
                    end
                pbts_pkg::OP_SCHEDULE:
                    sw = dispatch();
                default:
                    ;
            endcase
            any          = find_top(top);
            s.switch_now = sw;
            s.next_task  = any ? TW'(q_head[top]) : '0;
            s.none_ready = !any;
            s.top_prio   = top[PW-1:0];
            s.lock_level = LW'(lock_cnt);
            want_q.push_back(s);
        endfunction

        task report(string what, int got, int want_v);
            $display("[%0t] result %0d: %s is %0d, expected %0d",
                     $time, checked, what, got, want_v);
            errors++;
        endtask

        // Compare one delivered status item with the oldest prediction
        task check_result(status_t got);
            status_t w;
            if (want_q.size() == 0)
            begin
                report("unexpected result, pending count", 1, 0);
                return;
            end
            w = want_q.pop_front();
            if (got.switch_now !== w.switch_now)
                report("switch_now", int'(got.switch_now), int'(w.switch_now));
            if (got.next_task !== w.next_task)
                report("next_task", int'(got.next_task), int'(w.next_task));
            if (got.none_ready !== w.none_ready)
                report("none_ready", int'(got.none_ready), int'(w.none_ready));
            if (got.top_prio !== w.top_prio)
                report("top_prio", int'(got.top_prio), int'(w.top_prio));
            if (got.lock_level !== w.lock_level)
                report("lock_level", int'(got.lock_level), int'(w.lock_level));
            if (w.switch_now)
                switches++;
            if (w.none_ready)
                empties++;
            checked++;
        endtask
    endclass

    logic clk;
    logic rst_n;
    int   cycles;
    int   sent;
    int   hold;
    bit   idle_on;
    bit   stall_on;

    pbts_req_if req();
    pbts_rsp_if rsp();

    sched_scoreboard sb = new();

    priority_bitmap_task_scheduler_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Bound the run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("Run timed out after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Check results first, then note the request taken at the same edge
    always @(posedge clk)
    begin : watch
        status_t seen;
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                seen.switch_now = rsp.switch_now;
                seen.next_task  = rsp.next_task;
                seen.none_ready = rsp.none_ready;
                seen.top_prio   = rsp.top_prio;
                seen.lock_level = rsp.lock_level;
                sb.check_result(seen);
            end
            if (req.valid && req.ready)
                sb.note_request(req.operation, req.task_id, req.prio);
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
    endfunction

    // Stall the result channel at random while stalling is enabled
    always @(negedge clk)
    begin
        if (hold > 0)
        begin
            rsp.ready <= 1'b0;
            hold = hold - 1;
        end
        else
        begin
            rsp.ready <= 1'b1;
            if (stall_on && $urandom_range(0, 3) == 0)
                hold = pick_gap();
        end
    end

    // Drive one request from a falling edge and hold it until the transfer
    task send_op(int op, int t, int p);
        int gap;
        gap = (idle_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.valid     <= 1'b1;
        req.operation <= OPW'(op);
        req.task_id   <= TW'(t);
        req.prio      <= PW'(p);
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    // Crowd a few priorities so the queues grow long; touch every priority now and then
    function automatic int pick_prio();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 3);
        if (r < 80)
            return r[0] ? NP - 1 : 0;
        return $urandom_range(0, NP - 1);
    endfunction

    // Mostly a task that sits in a queue, else any task
    function automatic int pick_listed();
        int pool[$];
        for (int i = 0; i < NT; i++)
            if (sb.is_queued[i] || sb.is_ready[i])
                pool.push_back(i);
        if (pool.size() == 0 || $urandom_range(0, 4) == 0)
            return $urandom_range(0, NT - 1);
        return pool[$urandom_range(0, pool.size() - 1)];
    endfunction

    task list_item();
        int r;
        r = $urandom_range(0, 2);
        if (r == 0)
            send_op(pbts_pkg::OP_MAKE_READY, $urandom_range(0, NT - 1), pick_prio());
        else if (r == 1)
            send_op(pbts_pkg::OP_UNREADY, pick_listed(), $urandom_range(0, NP - 1));
        else
            send_op(pbts_pkg::OP_REMOVE, pick_listed(), $urandom_range(0, NP - 1));
    endtask

    task random_item();
        int r;
        int t;
        int p;
        int op;
        r = $urandom_range(0, 99);
        t = $urandom_range(0, NT - 1);
        p = pick_prio();
        if (r < 32)
            op = pbts_pkg::OP_MAKE_READY;
        else if (r < 44)
        begin
            op = pbts_pkg::OP_UNREADY;
            t  = pick_listed();
        end
        else if (r < 56)
        begin
            op = pbts_pkg::OP_REMOVE;
            t  = pick_listed();
        end
        else if (r < 65)
            op = pbts_pkg::OP_LOCK;
        else if (r < 77)
            op = pbts_pkg::OP_UNLOCK;
        else if (r < 96)
            op = pbts_pkg::OP_SCHEDULE;
        else
            op = r[0] ? OP_SPARE_6 : OP_SPARE_7;
        send_op(op, t, p);
    endtask

    // Drive the counter into saturation, work the lists while locked, then release
    task lock_ceiling_run();
        repeat (LOCK_TOP + 2)
            send_op(pbts_pkg::OP_LOCK, $urandom_range(0, NT - 1), $urandom_range(0, NP - 1));
        send_op(pbts_pkg::OP_SCHEDULE, 0, 0);
        repeat (LOCK_TOP)
        begin
            send_op(pbts_pkg::OP_UNLOCK, $urandom_range(0, NT - 1),
                    $urandom_range(0, NP - 1));
            if ($urandom_range(0, 4) == 0)
                list_item();
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cycles        = 0;
        sent          = 0;
        hold          = 0;
        idle_on       = 1'b0;
        stall_on      = 1'b0;
        req.valid     = 1'b0;
        req.operation = '0;
        req.task_id   = '0;
        req.prio      = '0;
        rsp.ready     = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed sequence: empty status, idle codes, queue edges, lock corners
        send_op(pbts_pkg::OP_SCHEDULE,   0,  0);
        send_op(pbts_pkg::OP_UNLOCK,     0,  0);
        send_op(OP_SPARE_6,             15, 31);
        send_op(OP_SPARE_7,              0,  0);
        send_op(pbts_pkg::OP_MAKE_READY, 0, 31);
        send_op(pbts_pkg::OP_MAKE_READY, 15, 0);
        send_op(pbts_pkg::OP_MAKE_READY, 15, 5);
        send_op(pbts_pkg::OP_SCHEDULE,   0,  0);
        send_op(pbts_pkg::OP_SCHEDULE,   0,  0);
        send_op(pbts_pkg::OP_MAKE_READY, 3,  0);
        send_op(pbts_pkg::OP_MAKE_READY, 7,  0);
        send_op(pbts_pkg::OP_LOCK,       0,  0);
        send_op(pbts_pkg::OP_REMOVE,     3,  9);
        send_op(pbts_pkg::OP_SCHEDULE,   0,  0);
        send_op(pbts_pkg::OP_UNREADY,    15, 20);
        send_op(pbts_pkg::OP_UNLOCK,     0,  0);
        send_op(pbts_pkg::OP_UNREADY,    15, 0);
        send_op(pbts_pkg::OP_MAKE_READY, 15, 0);
        send_op(pbts_pkg::OP_REMOVE,     15, 0);
        send_op(pbts_pkg::OP_UNREADY,    15, 0);
        send_op(pbts_pkg::OP_REMOVE,     9,  0);
        send_op(pbts_pkg::OP_UNREADY,    7,  0);
        send_op(pbts_pkg::OP_SCHEDULE,   0,  0);
        send_op(pbts_pkg::OP_REMOVE,     0, 31);
        send_op(pbts_pkg::OP_SCHEDULE,   0,  0);

        idle_on  = 1'b1;
        stall_on = 1'b1;
        lock_ceiling_run();

        // Random traffic; change the idling mix now and then
        for (int i = 0; i < RANDOM_OPS; i++)
        begin
            if (i % 64 == 0)
            begin
                idle_on  = $urandom_range(0, 3) != 0;
                stall_on = $urandom_range(0, 3) != 0;
            end
            random_item();
        end
        req.valid <= 1'b0;

        // Drain outstanding results, then watch for strays
        while (sb.want_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Sent %0d requests, checked %0d results in %0d cycles",
                 sent, sb.checked, cycles);
        $display("Saw %0d switch requests, %0d empty reports, %0d locks at the ceiling",
                 sb.switches, sb.empties, sb.sat_hits);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
